### sv/cfar_signal_activity_detector_assert.svh
// Assertion macros shared by the activity detector RTL.
`ifndef CFAR_SIGNAL_ACTIVITY_DETECTOR_ASSERT_SVH
`define CFAR_SIGNAL_ACTIVITY_DETECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define CSAD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csad implication check failed");
`define CSAD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csad next-cycle check failed");
`else
`define CSAD_ASSERT_IMPL(name, ante, cons)
`define CSAD_ASSERT_NEXT(name, ante, cons)
`endif
`endif

### sv/csad_pkg.sv
// Shared constants, register indexes and types of the activity detector.
`default_nettype none
package csad_pkg;
    localparam int WINDOW_DEF      = 20;
    localparam int ENERGY_BITS_DEF = 32;
    localparam int ENERGY_IN_BITS  = 32;
    localparam int CFG_IDX_BITS    = 3;
    localparam int CFG_DATA_BITS   = 16;

    localparam logic [CFG_IDX_BITS-1:0] REG_DETECT_FACTOR  = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_GUARD_CELLS    = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_FRACTION   = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_END_FRAMES     = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_HOLDOFF_FRAMES = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] REG_AVERAGE_WEIGHT = 3'd5;

    localparam logic [7:0]  RST_DETECT_FACTOR  = 8'd10;
    localparam logic [3:0]  RST_GUARD_CELLS    = 4'd2;
    localparam logic [7:0]  RST_END_FRACTION   = 8'd77;
    localparam logic [15:0] RST_END_FRAMES     = 16'd200;
    localparam logic [7:0]  RST_HOLDOFF_FRAMES = 8'd50;
    localparam logic [7:0]  RST_AVERAGE_WEIGHT = 8'd26;

    localparam logic [1:0] PH_FILL    = 2'd0;
    localparam logic [1:0] PH_ARMED   = 2'd1;
    localparam logic [1:0] PH_HOLDOFF = 2'd2;
    localparam logic [1:0] PH_TRACK   = 2'd3;

    typedef struct packed {
        logic shift;
        logic add_en;
    } t_cell_ctrl;
endpackage
`default_nettype wire

### sv/csad_cell.sv
// One ring cell: holds an energy entry and, when enabled, adds it to the partial sum passing by.
`default_nettype none
module csad_cell #(
    parameter int ENERGY_BITS = csad_pkg::ENERGY_BITS_DEF,
    parameter int SUM_BITS    = csad_pkg::ENERGY_BITS_DEF + 5
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  csad_pkg::t_cell_ctrl    i_ctrl,
    input  logic [ENERGY_BITS-1:0]  i_entry,
    output logic [ENERGY_BITS-1:0]  o_entry,
    input  logic [SUM_BITS-1:0]     i_psum,
    output logic [SUM_BITS-1:0]     o_psum,
    input  logic                    i_tok,
    output logic                    o_tok
);
    logic [ENERGY_BITS-1:0] r_entry;
    logic [SUM_BITS-1:0]    r_psum;
    logic                   r_tok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok <= 1'b0;
        end else begin
            r_tok <= i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.shift) begin
            r_entry <= i_entry;
        end
        r_psum <= i_psum + (i_ctrl.add_en ? SUM_BITS'(r_entry) : '0);
    end

    assign o_entry = r_entry;
    assign o_psum  = r_psum;
    assign o_tok   = r_tok;
endmodule
`default_nettype wire

### sv/cfar_signal_activity_detector.sv
// Top level of the cell-averaging CFAR activity detector with end tracking.
//
//   channel   direction  handshake            payload
//   input     in         i_valid / o_stall    i_energy
//   output    out        o_valid / i_stall    o_active, o_phase, o_start_seen,
//                                             o_end_seen, o_capture_template
//   config    in         i_cfg_we             i_cfg_idx, i_cfg_data
//
// One item is worked on at a time. While armed, an item goes through these steps:
// the partial sum walks the row of WINDOW cells one cell per cycle, then the
// products are formed, then compared, and the result is handed over. While filling,
// or while a signal is active, an item skips the walk. Reset is synchronous and
// clears all control state; ring contents are unused until the ring is full.
// A waiting result does not block the next item until that item's own result is due.
`default_nettype none
`include "cfar_signal_activity_detector_assert.svh"
module cfar_signal_activity_detector #(
    parameter int WINDOW      = csad_pkg::WINDOW_DEF,
    parameter int ENERGY_BITS = csad_pkg::ENERGY_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic [csad_pkg::ENERGY_IN_BITS-1:0]  i_energy,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_active,
    output logic [1:0]                           o_phase,
    output logic                                 o_start_seen,
    output logic                                 o_end_seen,
    output logic                                 o_capture_template,
    input  logic                                 i_cfg_we,
    input  logic [csad_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [csad_pkg::CFG_DATA_BITS-1:0]   i_cfg_data
);
    localparam int CNTW = $clog2(WINDOW + 1);
    localparam int SUMW = ENERGY_BITS + CNTW;
    localparam int CLW  = ENERGY_BITS + CNTW;
    localparam int CPW  = SUMW + 8;
    localparam int EPW  = ENERGY_BITS + 8;
    localparam int KPW  = ENERGY_BITS + 9;
    localparam int APW  = ENERGY_BITS + 10;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SUM  = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_EVAL = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [7:0]  r_factor;
    logic [3:0]  r_guard;
    logic [7:0]  r_frac;
    logic [15:0] r_end_frames;
    logic [7:0]  r_holdoff;
    logic [7:0]  r_weight;

    logic [2:0]      r_state;
    logic            r_launch;
    logic            r_detected;
    logic [CNTW-1:0] r_fill;
    logic [7:0]      r_hc;
    logic            r_ref_valid;
    logic [15:0]     r_low_run;
    logic            r_out_valid;

    logic [ENERGY_BITS-1:0] r_e;
    logic [ENERGY_BITS-1:0] r_ref;
    logic [SUMW-1:0]        r_sum;
    logic [CLW-1:0]         r_cfar_lhs;
    logic [CPW-1:0]         r_cfar_rhs;
    logic [EPW-1:0]         r_low_rhs;
    logic [KPW-1:0]         r_keep;
    logic [EPW-1:0]         r_new;

    logic       r_res_active;
    logic [1:0] r_res_phase;
    logic       r_res_start;
    logic       r_res_end;
    logic       r_res_cap;
    logic       r_out_active;
    logic [1:0] r_out_phase;
    logic       r_out_start;
    logic       r_out_end;
    logic       r_out_cap;

    logic [ENERGY_BITS+31:0] w_e_wide;
    logic [ENERGY_BITS-1:0]  w_e_in;
    logic                    w_accept;
    logic                    w_shift;
    logic [CNTW-1:0]         w_fill_inc;
    logic                    w_full_next;
    logic [7:0]              w_hl;
    logic                    w_hc_run;
    logic [7:0]              w_hc_inc;
    logic                    w_cap;
    logic                    w_end_chk;
    logic [31:0]             w_guard_w;
    logic [CNTW-1:0]         w_count;
    logic                    w_start;
    logic                    w_low;
    logic [15:0]             n_low_run;
    logic                    w_end;
    logic [APW-1:0]          n_avg;
    logic [ENERGY_BITS-1:0]  n_ref;
    logic [8:0]              w_keep_w;

    csad_pkg::t_cell_ctrl   w_ctrl  [WINDOW];
    logic [ENERGY_BITS-1:0] w_entry [WINDOW];
    logic [SUMW-1:0]        w_psum  [WINDOW];
    logic [WINDOW-1:0]      w_tok;
    logic [WINDOW:0]        w_tok_all;

    assign w_e_wide  = {{ENERGY_BITS{1'b0}}, i_energy};
    assign w_e_in    = w_e_wide[ENERGY_BITS-1:0];
    assign o_stall   = (r_state != S_IDLE);
    assign w_accept  = i_valid && !o_stall;
    assign w_shift   = w_accept && !r_detected;

    assign w_fill_inc  = (r_fill == CNTW'(WINDOW)) ? r_fill : r_fill + CNTW'(1);
    assign w_full_next = (w_fill_inc == CNTW'(WINDOW));

    assign w_hl      = (r_holdoff == 8'd0) ? 8'd1 : r_holdoff;
    assign w_hc_run  = (r_hc < w_hl);
    assign w_hc_inc  = w_hc_run ? r_hc + 8'd1 : r_hc;
    assign w_cap     = w_hc_run && (w_hc_inc == w_hl);
    assign w_end_chk = (w_hc_inc >= w_hl);

    assign w_guard_w = 32'(r_guard);
    assign w_count   = (w_guard_w >= 32'(WINDOW)) ? '0 : CNTW'(32'(WINDOW) - w_guard_w);

    assign w_start   = (w_count == '0) ? (r_e != '0) : (CPW'(r_cfar_lhs) > r_cfar_rhs);
    assign w_low     = ({r_e, 8'h00} < r_low_rhs);
    assign n_low_run = (r_low_run == 16'hFFFF) ? r_low_run : r_low_run + 16'd1;
    assign w_end     = (n_low_run >= r_end_frames);
    assign n_avg     = APW'(r_keep) + APW'(r_new);
    assign n_ref     = n_avg[ENERGY_BITS+7:8];
    assign w_keep_w  = 9'd256 - {1'b0, r_weight};

    // Row of cells: index k holds the k-th newest energy; the sum token enters at cell 0.
    genvar k;
    generate
        for (k = 0; k < WINDOW; k++) begin : g_cell
            assign w_ctrl[k].shift  = w_shift;
            assign w_ctrl[k].add_en = (w_guard_w <= 32'(k));
            if (k == 0) begin : g_head
                csad_cell #(
                    .ENERGY_BITS (ENERGY_BITS),
                    .SUM_BITS    (SUMW)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl[k]),
                    .i_entry (w_e_in),
                    .o_entry (w_entry[k]),
                    .i_psum  ('0),
                    .o_psum  (w_psum[k]),
                    .i_tok   (r_launch),
                    .o_tok   (w_tok[k])
                );
            end else begin : g_body
                csad_cell #(
                    .ENERGY_BITS (ENERGY_BITS),
                    .SUM_BITS    (SUMW)
                ) u_cell (
                    .i_clk   (i_clk),
                    .i_rst_n (i_rst_n),
                    .i_ctrl  (w_ctrl[k]),
                    .i_entry (w_entry[k-1]),
                    .o_entry (w_entry[k]),
                    .i_psum  (w_psum[k-1]),
                    .o_psum  (w_psum[k]),
                    .i_tok   (w_tok[k-1]),
                    .o_tok   (w_tok[k])
                );
            end
        end
    endgenerate

    assign w_tok_all = {w_tok, r_launch};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor     <= csad_pkg::RST_DETECT_FACTOR;
            r_guard      <= csad_pkg::RST_GUARD_CELLS;
            r_frac       <= csad_pkg::RST_END_FRACTION;
            r_end_frames <= csad_pkg::RST_END_FRAMES;
            r_holdoff    <= csad_pkg::RST_HOLDOFF_FRAMES;
            r_weight     <= csad_pkg::RST_AVERAGE_WEIGHT;
            r_state      <= S_IDLE;
            r_launch     <= 1'b0;
            r_detected   <= 1'b0;
            r_fill       <= '0;
            r_hc         <= 8'd0;
            r_ref_valid  <= 1'b0;
            r_low_run    <= 16'd0;
            r_out_valid  <= 1'b0;
        end else begin
            r_launch <= w_shift && w_full_next;
            if ((r_state == S_DONE) && (!r_out_valid || !i_stall)) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    csad_pkg::REG_DETECT_FACTOR:  r_factor     <= i_cfg_data[7:0];
                    csad_pkg::REG_GUARD_CELLS:    r_guard      <= i_cfg_data[3:0];
                    csad_pkg::REG_END_FRACTION:   r_frac       <= i_cfg_data[7:0];
                    csad_pkg::REG_END_FRAMES:     r_end_frames <= i_cfg_data[15:0];
                    csad_pkg::REG_HOLDOFF_FRAMES: r_holdoff    <= i_cfg_data[7:0];
                    csad_pkg::REG_AVERAGE_WEIGHT: r_weight     <= i_cfg_data[7:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (!r_detected) begin
                            r_fill <= w_fill_inc;
                            if (w_full_next) begin
                                r_state <= S_SUM;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_hc <= w_hc_inc;
                            if (w_end_chk && r_ref_valid) begin
                                r_state <= S_MUL;
                            end else begin
                                if (w_end_chk) begin
                                    r_ref_valid <= 1'b1;
                                    r_low_run   <= 16'd0;
                                end
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_SUM: begin
                    if (w_tok[WINDOW-1]) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (!r_detected) begin
                        if (w_start) begin
                            r_detected  <= 1'b1;
                            r_hc        <= 8'd0;
                            r_ref_valid <= 1'b0;
                            r_low_run   <= 16'd0;
                        end
                    end else if (w_low) begin
                        if (w_end) begin
                            r_detected  <= 1'b0;
                            r_ref_valid <= 1'b0;
                            r_low_run   <= 16'd0;
                            r_hc        <= 8'd0;
                        end else begin
                            r_low_run <= n_low_run;
                        end
                    end else begin
                        r_low_run <= 16'd0;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || !i_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_e         <= w_e_in;
            r_res_start <= 1'b0;
            r_res_end   <= 1'b0;
            if (!r_detected) begin
                r_res_active <= 1'b0;
                r_res_phase  <= w_full_next ? csad_pkg::PH_ARMED : csad_pkg::PH_FILL;
                r_res_cap    <= 1'b0;
            end else begin
                r_res_active <= 1'b1;
                r_res_phase  <= w_end_chk ? csad_pkg::PH_TRACK : csad_pkg::PH_HOLDOFF;
                r_res_cap    <= w_cap;
                if (w_end_chk && !r_ref_valid) begin
                    r_ref <= w_e_in;
                end
            end
        end
        if ((r_state == S_SUM) && w_tok[WINDOW-1]) begin
            r_sum <= w_psum[WINDOW-1];
        end
        if (r_state == S_MUL) begin
            r_cfar_lhs <= CLW'(r_e) * CLW'(w_count);
            r_cfar_rhs <= CPW'(r_factor) * CPW'(r_sum);
            r_low_rhs  <= EPW'(r_ref) * EPW'(r_frac);
            r_keep     <= KPW'(r_ref) * KPW'(w_keep_w);
            r_new      <= EPW'(r_e) * EPW'(r_weight);
        end
        if (r_state == S_EVAL) begin
            if (!r_detected) begin
                r_res_start  <= w_start;
                r_res_active <= w_start;
                r_res_phase  <= w_start ? csad_pkg::PH_HOLDOFF : csad_pkg::PH_ARMED;
            end else if (w_low) begin
                if (w_end) begin
                    r_res_end    <= 1'b1;
                    r_res_active <= 1'b0;
                    r_res_phase  <= csad_pkg::PH_ARMED;
                end
            end else begin
                r_ref <= n_ref;
            end
        end
        if ((r_state == S_DONE) && (!r_out_valid || !i_stall)) begin
            r_out_active <= r_res_active;
            r_out_phase  <= r_res_phase;
            r_out_start  <= r_res_start;
            r_out_end    <= r_res_end;
            r_out_cap    <= r_res_cap;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_active           = r_out_active;
    assign o_phase            = r_out_phase;
    assign o_start_seen       = r_out_start;
    assign o_end_seen         = r_out_end;
    assign o_capture_template = r_out_cap;

    `CSAD_ASSERT_IMPL(a_start_in_holdoff, o_valid && o_start_seen, o_active && (o_phase == csad_pkg::PH_HOLDOFF))
    `CSAD_ASSERT_IMPL(a_end_to_armed, o_valid && o_end_seen, !o_active && (o_phase == csad_pkg::PH_ARMED))
    `CSAD_ASSERT_IMPL(a_single_token, 1'b1, $onehot0(w_tok_all))
    `CSAD_ASSERT_IMPL(a_detect_needs_full, r_detected, r_fill == CNTW'(WINDOW))
    `CSAD_ASSERT_NEXT(a_no_sum_when_active, w_accept && r_detected, r_state != S_SUM)
endmodule
`default_nettype wire

### dv/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench of the CFAR activity detector: a directed table, then random frame runs.
module tb;
    localparam int WINDOW = csad_pkg::WINDOW_DEF;
    localparam logic [csad_pkg::CFG_IDX_BITS-1:0] REG_SPARE_A = 3'd6;
    localparam logic [csad_pkg::CFG_IDX_BITS-1:0] REG_SPARE_B = 3'd7;
    localparam int RANDOM_FRAMES = 700;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic       active;
        logic [1:0] phase;
        logic       start_seen;
        logic       end_seen;
        logic       capture;
    } t_frame_result;

    localparam t_frame_result FILLING_FRAME = {1'b0, csad_pkg::PH_FILL, 3'b000};
    localparam t_frame_result ARMED_FRAME   = {1'b0, csad_pkg::PH_ARMED, 3'b000};
    localparam t_frame_result START_FRAME   = {1'b1, csad_pkg::PH_HOLDOFF, 3'b100};
    localparam t_frame_result CAPTURE_FRAME = {1'b1, csad_pkg::PH_TRACK, 3'b001};
    localparam t_frame_result END_FRAME     = {1'b0, csad_pkg::PH_ARMED, 3'b010};

    typedef enum logic {ROW_ITEM, ROW_REG} t_row_kind;

    typedef struct packed {
        t_row_kind                          kind;
        logic [csad_pkg::CFG_IDX_BITS-1:0]  idx;
        logic [31:0]                        value;
        logic [4:0]                         reps;
        logic                               typed;
        t_frame_result                      want;
    } t_stim_row;

    t_stim_row directed_rows [28] = '{
        '{ROW_ITEM, '0, 32'h0000_0000, 5'd1, 1'b1, FILLING_FRAME},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 5'd1, 1'b1, FILLING_FRAME},
        '{ROW_ITEM, '0, 32'h0000_0001, 5'd17, 1'b1, FILLING_FRAME},
        '{ROW_ITEM, '0, 32'h0000_0001, 5'd1, 1'b1, ARMED_FRAME},
        '{ROW_REG, csad_pkg::REG_HOLDOFF_FRAMES, 32'h0, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_END_FRAMES, 32'h0, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_DETECT_FACTOR, 32'h0, 5'd0, 1'b0, '0},
        '{ROW_ITEM, '0, 32'h0000_0000, 5'd1, 1'b1, ARMED_FRAME},
        '{ROW_ITEM, '0, 32'h0000_0001, 5'd1, 1'b1, START_FRAME},
        '{ROW_ITEM, '0, 32'h0000_0005, 5'd1, 1'b1, CAPTURE_FRAME},
        '{ROW_ITEM, '0, 32'h0000_0000, 5'd1, 1'b1, END_FRAME},
        '{ROW_REG, csad_pkg::REG_DETECT_FACTOR, 32'd255, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_GUARD_CELLS, 32'd15, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_END_FRACTION, 32'd255, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_END_FRAMES, 32'hFFFF, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_HOLDOFF_FRAMES, 32'd255, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_AVERAGE_WEIGHT, 32'd255, 5'd0, 1'b0, '0},
        '{ROW_REG, REG_SPARE_A, 32'hFFFF, 5'd0, 1'b0, '0},
        '{ROW_REG, REG_SPARE_B, 32'h0, 5'd0, 1'b0, '0},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 5'd1, 1'b0, '0},
        '{ROW_ITEM, '0, 32'h8000_0000, 5'd2, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_HOLDOFF_FRAMES, 32'd2, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_END_FRAMES, 32'd1, 5'd0, 1'b0, '0},
        '{ROW_ITEM, '0, 32'h0001_0000, 5'd1, 1'b0, '0},
        '{ROW_ITEM, '0, 32'hFFFF_FFFF, 5'd1, 1'b0, '0},
        '{ROW_ITEM, '0, 32'h0000_0000, 5'd1, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_AVERAGE_WEIGHT, 32'd0, 5'd0, 1'b0, '0},
        '{ROW_REG, csad_pkg::REG_GUARD_CELLS, 32'd0, 5'd0, 1'b0, '0}
    };

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_valid = 1'b0;
    logic                                o_stall;
    logic [csad_pkg::ENERGY_IN_BITS-1:0] i_energy = '0;
    logic                                o_valid;
    logic                                i_stall = 1'b0;
    logic                                o_active;
    logic [1:0]                          o_phase;
    logic                                o_start_seen;
    logic                                o_end_seen;
    logic                                o_capture_template;
    logic                                i_cfg_we = 1'b0;
    logic [csad_pkg::CFG_IDX_BITS-1:0]   i_cfg_idx = '0;
    logic [csad_pkg::CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    logic [7:0]  cfg_detect = csad_pkg::RST_DETECT_FACTOR;
    logic [3:0]  cfg_guard = csad_pkg::RST_GUARD_CELLS;
    logic [7:0]  cfg_end_fraction = csad_pkg::RST_END_FRACTION;
    logic [15:0] cfg_end_frames = csad_pkg::RST_END_FRAMES;
    logic [7:0]  cfg_holdoff = csad_pkg::RST_HOLDOFF_FRAMES;
    logic [7:0]  cfg_avg_weight = csad_pkg::RST_AVERAGE_WEIGHT;

    logic [31:0] ring [WINDOW] = '{default: '0};
    int          ring_pos = 0;
    int          ring_fill = 0;
    bit          sig_present = 1'b0;
    int          hold_cnt = 0;
    bit          ref_valid = 1'b0;
    logic [63:0] ref_energy = '0;
    int          low_run = 0;

    t_frame_result pending_frames[$];
    int            bad_frames = 0;
    int            frames_out = 0;
    int            stall_left = 0;
    int            random_items = 0;
    bit            tx_quiet = 1'b0;
    bit            rx_quiet = 1'b0;

    cfar_signal_activity_detector uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_energy           (i_energy),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_active           (o_active),
        .o_phase            (o_phase),
        .o_start_seen       (o_start_seen),
        .o_end_seen         (o_end_seen),
        .o_capture_template (o_capture_template),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_idx          (i_cfg_idx),
        .i_cfg_data         (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic predict_frame(input logic [31:0] e, output t_frame_result r);
        logic [63:0] bg_sum;
        logic [63:0] bg_count;
        int          hl;
        bit          fired;
        bit          ended;
        r = '0;
        hl = (cfg_holdoff == 0) ? 1 : int'(cfg_holdoff);
        if (!sig_present) begin
            ring[ring_pos] = e;
            ring_pos = (ring_pos + 1) % WINDOW;
            if (ring_fill < WINDOW) ring_fill++;
            if (ring_fill == WINDOW) begin
                bg_sum = '0;
                bg_count = '0;
                for (int i = int'(cfg_guard); i < WINDOW; i++) begin
                    bg_sum += ring[(ring_pos + 2 * WINDOW - 1 - i) % WINDOW];
                    bg_count++;
                end
                if (bg_count == 0)
                    fired = (e != 0);
                else
                    fired = (64'(e) * bg_count > 64'(cfg_detect) * bg_sum);
                if (fired) begin
                    sig_present = 1'b1;
                    hold_cnt = 0;
                    ref_valid = 1'b0;
                    low_run = 0;
                    r.start_seen = 1'b1;
                end
            end
        end else begin
            if (hold_cnt < hl) begin
                hold_cnt++;
                if (hold_cnt == hl) r.capture = 1'b1;
            end
            if (hold_cnt >= hl) begin
                ended = 1'b0;
                if (!ref_valid) begin
                    ref_energy = 64'(e);
                    ref_valid = 1'b1;
                    low_run = 0;
                end else if (64'(e) * 256 < ref_energy * 64'(cfg_end_fraction)) begin
                    if (low_run < 65535) low_run++;
                    ended = (low_run >= int'(cfg_end_frames));
                end else begin
                    low_run = 0;
                    ref_energy = (ref_energy * (64'd256 - 64'(cfg_avg_weight))
                                  + 64'(e) * 64'(cfg_avg_weight)) >> 8;
                end
                if (ended) begin
                    sig_present = 1'b0;
                    ref_valid = 1'b0;
                    low_run = 0;
                    hold_cnt = 0;
                    r.end_seen = 1'b1;
                end
            end
        end
        r.active = sig_present;
        if (sig_present)
            r.phase = (hold_cnt < hl) ? csad_pkg::PH_HOLDOFF : csad_pkg::PH_TRACK;
        else
            r.phase = (ring_fill < WINDOW) ? csad_pkg::PH_FILL : csad_pkg::PH_ARMED;
    endtask

    task automatic send_energy(input logic [31:0] e, input logic typed,
                               input t_frame_result typed_frame);
        int            gap;
        t_frame_result predicted;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        i_cfg_we <= 1'b0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid  <= 1'b1;
        i_energy <= e;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        predict_frame(e, predicted);
        pending_frames.push_back(typed ? typed_frame : predicted);
    endtask

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [csad_pkg::CFG_IDX_BITS-1:0] idx,
                             input logic [csad_pkg::CFG_DATA_BITS-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            csad_pkg::REG_DETECT_FACTOR:  cfg_detect = data[7:0];
            csad_pkg::REG_GUARD_CELLS:    cfg_guard = data[3:0];
            csad_pkg::REG_END_FRACTION:   cfg_end_fraction = data[7:0];
            csad_pkg::REG_END_FRAMES:     cfg_end_frames = data;
            csad_pkg::REG_HOLDOFF_FRAMES: cfg_holdoff = data[7:0];
            csad_pkg::REG_AVERAGE_WEIGHT: cfg_avg_weight = data[7:0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] one_of(input logic [15:0] a, input logic [15:0] b,
                                           input logic [15:0] c);
        case ($urandom_range(0, 2))
            0: return a;
            1: return b;
            default: return c;
        endcase
    endfunction

    task automatic run_segment();
        bit          rare;
        bit          first;
        logic [31:0] bg_level;
        logic [31:0] burst_level;
        first = (random_items == 0);
        tx_quiet = ($urandom_range(0, 3) == 0);
        rx_quiet = ($urandom_range(0, 3) == 0);
        rare = ($urandom_range(0, 7) == 0);
        if (first || $urandom_range(0, 1))
            write_reg(csad_pkg::REG_DETECT_FACTOR,
                      rare ? one_of(16'd0, 16'd1, 16'd255) : 16'($urandom_range(2, 20)));
        if (first || $urandom_range(0, 1))
            write_reg(csad_pkg::REG_GUARD_CELLS, 16'($urandom_range(0, 15)));
        if (first || $urandom_range(0, 1))
            write_reg(csad_pkg::REG_END_FRACTION,
                      rare ? one_of(16'd0, 16'd1, 16'd255) : 16'($urandom_range(16, 250)));
        if (first || $urandom_range(0, 1))
            write_reg(csad_pkg::REG_END_FRAMES,
                      ($urandom_range(0, 7) == 0)
                          ? one_of(16'd0, 16'hFFFF, 16'($urandom_range(9, 300)))
                          : 16'($urandom_range(1, 8)));
        if (first || $urandom_range(0, 1))
            write_reg(csad_pkg::REG_HOLDOFF_FRAMES,
                      ($urandom_range(0, 7) == 0)
                          ? one_of(16'd0, 16'd255, 16'($urandom_range(9, 40)))
                          : 16'($urandom_range(1, 8)));
        if (first || $urandom_range(0, 1))
            write_reg(csad_pkg::REG_AVERAGE_WEIGHT,
                      rare ? one_of(16'd0, 16'd255, 16'd128) : 16'($urandom_range(1, 254)));
        if ($urandom_range(0, 9) == 0)
            write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, 16'($urandom));

        if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(1, 20)) begin
                send_energy($urandom, 1'b0, '0);
                random_items++;
            end
        end else begin
            bg_level = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 32'h00FF_FFFF)
                                                   : $urandom_range(0, 32'h0000_FFFF);
            burst_level = $urandom_range(32'h0100_0000, 32'hFFFF_FFFF);
            repeat ($urandom_range(0, 12)) begin
                send_energy(bg_level + $urandom_range(0, bg_level >> 2), 1'b0, '0);
                random_items++;
            end
            repeat ($urandom_range(1, 16)) begin
                send_energy(burst_level - $urandom_range(0, burst_level >> 3), 1'b0, '0);
                random_items++;
            end
            repeat ($urandom_range(0, 16)) begin
                send_energy(($urandom_range(0, 2) == 0) ? $urandom_range(0, burst_level)
                                                        : $urandom_range(0, 255),
                            1'b0, '0);
                random_items++;
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_result got;
        t_frame_result want;
        int            n;
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            stall_left <= 0;
        end else if (o_valid === 1'b1 && !i_stall) begin
            got = {o_active, o_phase, o_start_seen, o_end_seen, o_capture_template};
            if (pending_frames.size() == 0) begin
                bad_frames++;
                if (bad_frames <= MAX_REPORTS)
                    $display("ERROR: frame result %0d arrived with none expected: %b",
                             frames_out, got);
            end else begin
                want = pending_frames.pop_front();
                if (got.active !== want.active || got.phase !== want.phase
                    || got.start_seen !== want.start_seen || got.end_seen !== want.end_seen
                    || got.capture !== want.capture) begin
                    bad_frames++;
                    if (bad_frames <= MAX_REPORTS)
                        $display("ERROR: result %0d: expected %b, got %b (act,ph,st,end,cap)",
                                 frames_out, want, got);
                end
            end
            frames_out++;
            n = rx_quiet ? 0 : $urandom_range(0, 14);
            i_stall <= (n != 0);
            stall_left <= n;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            i_stall <= (stall_left > 1);
        end
    end

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_REG) begin
                write_reg(directed_rows[k].idx,
                          directed_rows[k].value[csad_pkg::CFG_DATA_BITS-1:0]);
            end else begin
                for (int j = 0; j < directed_rows[k].reps; j++)
                    send_energy(directed_rows[k].value, directed_rows[k].typed,
                                directed_rows[k].want);
            end
        end

        while (random_items < RANDOM_FRAMES) run_segment();

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (pending_frames.size() != 0) begin
            bad_frames += pending_frames.size();
            $display("ERROR: %0d frame results never arrived", pending_frames.size());
        end
        if (bad_frames == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end
endmodule
